// ----- design/scff_pkg.sv -----
package scff_pkg;

  // Block sizing
  localparam int NUM_STRIPS = 256;
  localparam int CUT_DEPTH  = 16;
  localparam int ADC_BITS   = 12;

  localparam int POS_W = $clog2(NUM_STRIPS);
  localparam int CUT_W = $clog2(CUT_DEPTH);

  // Field widths fixed by the stream format
  localparam int ADC_W     = 12;
  localparam int PED_W     = 16;
  localparam int SIG_W     = 12;
  localparam int CHG_W     = 16;
  localparam int PROD_W    = 20;
  localparam int IDX_W     = 4;
  localparam int SUM_W     = 24;
  localparam int SIZE_W    = 9;
  localparam int FIRST_W   = 8;
  localparam int NCLUS_W   = 8;
  localparam int MULT_W    = 8;
  localparam int EN_W      = 3;

  localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((33'd1 << ADC_BITS) - 33'd1);

  // Stream packing
  localparam int IN_FIELDS_W  = ADC_W + PED_W + SIG_W + IDX_W + SUM_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = FIRST_W + SIZE_W + SUM_W + NCLUS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HIT_MULT      = 3'd0,
    REG_CUT_ENABLES   = 3'd1,
    REG_SINGLET_MULT  = 3'd2,
    REG_DOUBLET_MULT  = 3'd3,
    REG_DOUBLET_FLOOR = 3'd4
  } cfg_reg_e;

  // Input item kinds, result kinds, cut enable bits
  localparam logic MODE_STRIP     = 1'b0;
  localparam logic MODE_CUT_WRITE = 1'b1;
  localparam logic KIND_CLUSTER   = 1'b0;
  localparam logic KIND_SUMMARY   = 1'b1;
  localparam int   EN_SINGLET     = 0;
  localparam int   EN_DOUBLET     = 1;
  localparam int   EN_CHARGE      = 2;

  // Result queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [MULT_W-1:0] hit_mult;
    logic [EN_W-1:0]   enables;
    logic [MULT_W-1:0] singlet_mult;
    logic [MULT_W-1:0] doublet_mult;
    logic [SUM_W-1:0]  doublet_floor;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              mode;
    logic              last_strip;
    logic              hit;
    logic [CHG_W-1:0]  charge;
    logic [SIG_W-1:0]  sigma;
    logic [IDX_W-1:0]  cut_index;
    logic [SUM_W-1:0]  cut_value;
  } strip_t;

  typedef struct packed {
    logic               kind;
    logic [FIRST_W-1:0] first_strip;
    logic [SIZE_W-1:0]  strip_count;
    logic [SUM_W-1:0]   total_charge;
    logic [NCLUS_W-1:0] cluster_count;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic    rec_valid;
    logic    sum_valid;
    result_t rec;
    result_t summ;
  } push_t;

endpackage

// ----- design/scff_hit.sv -----
module scff_hit
  import scff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_transfer,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  cfg_t                  cfg,
  output logic                  in_busy,
  output strip_t                strip
);

  // Input register
  logic                  in_valid;
  logic [IN_TDATA_W-1:0] in_data;
  logic                  in_mode;
  logic                  in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_transfer;
    end
    if (in_transfer) begin
      in_data <= in_tdata;
      in_mode <= in_tuser;
      in_last <= in_tlast;
    end
  end

  assign in_busy = in_valid;

  // Unpack and work out the strip charge and hit decision
  logic [ADC_W-1:0]  adc;
  logic [PED_W-1:0]  ped;
  logic [SIG_W-1:0]  sig;
  logic [IDX_W-1:0]  idx;
  logic [SUM_W-1:0]  val;
  logic [CHG_W-1:0]  adc16;
  logic [CHG_W-1:0]  charge;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;
  logic              hit;

  always_comb begin
    adc    = in_data[ADC_W-1:0] & ADC_MASK;
    ped    = in_data[ADC_W +: PED_W];
    sig    = in_data[ADC_W+PED_W +: SIG_W];
    idx    = in_data[ADC_W+PED_W+SIG_W +: IDX_W];
    val    = in_data[ADC_W+PED_W+SIG_W+IDX_W +: SUM_W];
    adc16  = {adc, 4'b0000};
    charge = adc16 - ped;
    lhs    = {charge, 4'b0000};
    rhs    = PROD_W'(cfg.hit_mult) * PROD_W'(sig);
    hit    = (adc16 > ped) && (lhs > rhs);
  end

  // Hit register
  always_ff @(posedge clk) begin
    if (rst) begin
      strip.valid <= 1'b0;
    end else begin
      strip.valid <= in_valid;
    end
    strip.mode       <= in_mode;
    strip.last_strip <= in_last;
    strip.hit        <= hit;
    strip.charge     <= charge;
    strip.sigma      <= sig;
    strip.cut_index  <= idx;
    strip.cut_value  <= val;
  end

endmodule

// ----- design/scff_cluster.sv -----
module scff_cluster
  import scff_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  strip_t strip,
  output push_t  push
);

  // Event and cluster state
  logic [POS_W-1:0]   pos, pos_next;
  logic               in_cluster, in_cluster_next;
  logic [POS_W-1:0]   start, start_next;
  logic [SIZE_W-1:0]  size, size_next;
  logic [SUM_W-1:0]   sum, sum_next;
  logic [CHG_W-1:0]   q0, q0_next, q1, q1_next;
  logic [SIG_W-1:0]   s0, s0_next, s1, s1_next;
  logic [NCLUS_W-1:0] kept, kept_next;
  logic [SUM_W-1:0]   cut_table [CUT_DEPTH];

  logic               strip_v;
  logic               tab_we;
  logic               ev_last;
  logic               active;
  logic               close;
  logic               keep;
  logic [SUM_W:0]     sum_ext;
  logic [CUT_W-1:0]   cut_sel;
  logic [PROD_W-1:0]  lhs0, lhs1, sgl_rhs, dbl_rhs0, dbl_rhs1;
  logic [CHG_W:0]     pair;
  logic               dbl_low;

  always_comb begin
    strip_v = strip.valid && (strip.mode == MODE_STRIP);
    tab_we  = strip.valid && (strip.mode == MODE_CUT_WRITE) &&
              (int'(strip.cut_index) < CUT_DEPTH);
    ev_last = strip.last_strip || (pos == POS_W'(NUM_STRIPS - 1));

    // Cluster growth on a hit strip
    in_cluster_next = in_cluster;
    start_next      = start;
    size_next       = size;
    sum_next        = sum;
    q0_next         = q0;
    q1_next         = q1;
    s0_next         = s0;
    s1_next         = s1;
    sum_ext         = {1'b0, sum} + {{(SUM_W+1-CHG_W){1'b0}}, strip.charge};
    if (strip_v && strip.hit) begin
      in_cluster_next = 1'b1;
      if (!in_cluster) begin
        start_next = pos;
        size_next  = SIZE_W'(1);
        sum_next   = SUM_W'(strip.charge);
        q0_next    = strip.charge;
        s0_next    = strip.sigma;
        q1_next    = '0;
        s1_next    = '0;
      end else begin
        if (size == SIZE_W'(1)) begin
          q1_next = strip.charge;
          s1_next = strip.sigma;
        end
        if (size != '1) begin
          size_next = size + SIZE_W'(1);
        end
        sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end
    end

    // Filters on the cluster as it closes
    lhs0     = {q0_next, 4'b0000};
    lhs1     = {q1_next, 4'b0000};
    sgl_rhs  = PROD_W'(cfg.singlet_mult) * PROD_W'(s0_next);
    dbl_rhs0 = PROD_W'(cfg.doublet_mult) * PROD_W'(s0_next);
    dbl_rhs1 = PROD_W'(cfg.doublet_mult) * PROD_W'(s1_next);
    pair     = {1'b0, q0_next} + {1'b0, q1_next};
    dbl_low  = (lhs0 < dbl_rhs0) || (lhs1 < dbl_rhs1);
    cut_sel  = (int'(size_next) < CUT_DEPTH) ? CUT_W'(size_next) : CUT_W'(CUT_DEPTH - 1);
    keep     = 1'b1;
    if (cfg.enables[EN_SINGLET] && (size_next == SIZE_W'(1)) && !(lhs0 > sgl_rhs)) begin
      keep = 1'b0;
    end
    if (cfg.enables[EN_DOUBLET] && (size_next == SIZE_W'(2)) && dbl_low &&
        ({{(SUM_W-CHG_W-1){1'b0}}, pair} < cfg.doublet_floor)) begin
      keep = 1'b0;
    end
    if (cfg.enables[EN_CHARGE] && !(sum_next > cut_table[cut_sel])) begin
      keep = 1'b0;
    end

    active = in_cluster || strip.hit;
    close  = strip_v && active && (!strip.hit || ev_last);

    kept_next = kept;
    if (close) begin
      in_cluster_next = 1'b0;
      if (keep && (kept != '1)) begin
        kept_next = kept + NCLUS_W'(1);
      end
    end

    // Results
    push.rec_valid          = close && keep;
    push.rec.kind           = KIND_CLUSTER;
    push.rec.first_strip    = FIRST_W'(start_next);
    push.rec.strip_count    = size_next;
    push.rec.total_charge   = sum_next;
    push.rec.cluster_count  = '0;
    push.rec.last_result    = !ev_last;
    push.sum_valid          = strip_v && ev_last;
    push.summ.kind          = KIND_SUMMARY;
    push.summ.first_strip   = '0;
    push.summ.strip_count   = '0;
    push.summ.total_charge  = '0;
    push.summ.cluster_count = kept_next;
    push.summ.last_result   = 1'b1;

    // Position, cleared at event end
    pos_next = pos + POS_W'(1);
    if (ev_last) begin
      pos_next        = '0;
      in_cluster_next = 1'b0;
      start_next      = '0;
      size_next       = '0;
      sum_next        = '0;
      q0_next         = '0;
      q1_next         = '0;
      s0_next         = '0;
      s1_next         = '0;
      kept_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      in_cluster <= 1'b0;
      start      <= '0;
      size       <= '0;
      sum        <= '0;
      q0         <= '0;
      q1         <= '0;
      s0         <= '0;
      s1         <= '0;
      kept       <= '0;
      for (int i = 0; i < CUT_DEPTH; i++) begin
        cut_table[i] <= '0;
      end
    end else begin
      if (strip_v) begin
        pos        <= pos_next;
        in_cluster <= in_cluster_next;
        start      <= start_next;
        size       <= size_next;
        sum        <= sum_next;
        q0         <= q0_next;
        q1         <= q1_next;
        s0         <= s0_next;
        s1         <= s1_next;
        kept       <= kept_next;
      end
      if (tab_we) begin
        cut_table[CUT_W'(strip.cut_index)] <= strip.cut_value;
      end
    end
  end

endmodule

// ----- design/scff_res_fifo.sv -----
module scff_res_fifo
  import scff_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  input  logic              m_tready,
  output logic              m_tvalid,
  output result_t           head,
  output logic [QCNT_W-1:0] count
);

  result_t           entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              first_v;
  logic              second_v;
  result_t           first_res;
  logic              pop;
  logic [QCNT_W-1:0] n_push;

  // Up to two results enter per cycle, one leaves when the output is taken
  always_comb begin
    first_v   = push.rec_valid || push.sum_valid;
    second_v  = push.rec_valid && push.sum_valid;
    first_res = push.rec_valid ? push.rec : push.summ;
    pop       = m_tvalid && m_tready;
    n_push    = QCNT_W'(first_v) + QCNT_W'(second_v);
  end

  assign m_tvalid = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + n_push - QCNT_W'(pop);
    end
    if (first_v) begin
      entries[wr_ptr] <= first_res;
    end
    if (second_v) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.summ;
    end
  end

endmodule

// ----- design/strip_cluster_finder_filter_top.sv -----
// Path: input register, then hit register, then the result queue that drives the output.
// Throughput: one item per cycle while s_tready is high; results leave one per cycle
// from an 8-entry queue while m_tready is high. Input ready is held off when the queue
// cannot take two results for every item in flight. Reset: synchronous, active high;
// clears the config registers, valid flags, cut table, event state and the queue.
module strip_cluster_finder_filter_top
  import scff_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // tdata: adc_raw[11:0], pedestal[27:12], noise_sigma[39:28],
  //        cut_index[43:40], cut_value[67:44], zero pad
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,   // mode
  input  logic                   s_tlast,   // last_strip
  // tdata: first_strip[7:0], strip_count[16:8], total_charge[40:17],
  //        cluster_count[48:41], zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,   // kind
  output logic                   m_tlast,   // last_result
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t              cfg;
  strip_t            strip;
  push_t             push;
  result_t           head;
  logic [QCNT_W-1:0] count;
  logic              in_busy;
  logic [QCNT_W:0]   reserve;
  logic              in_transfer;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_addr))
        REG_HIT_MULT:      cfg.hit_mult      <= cfg_wdata[MULT_W-1:0];
        REG_CUT_ENABLES:   cfg.enables       <= cfg_wdata[EN_W-1:0];
        REG_SINGLET_MULT:  cfg.singlet_mult  <= cfg_wdata[MULT_W-1:0];
        REG_DOUBLET_MULT:  cfg.doublet_mult  <= cfg_wdata[MULT_W-1:0];
        REG_DOUBLET_FLOOR: cfg.doublet_floor <= cfg_wdata[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Room for two results per item in flight plus the one arriving
  always_comb begin
    reserve = {1'b0, count} + (QCNT_W+1)'(2) * ((QCNT_W+1)'(in_busy) + (QCNT_W+1)'(strip.valid));
    s_tready = (reserve <= (QCNT_W+1)'(QDEPTH - 2));
    in_transfer = s_tvalid && s_tready;
  end

  scff_hit u_hit (
    .clk         (clk),
    .rst         (rst),
    .in_transfer (in_transfer),
    .in_tdata    (s_tdata),
    .in_tuser    (s_tuser),
    .in_tlast    (s_tlast),
    .cfg         (cfg),
    .in_busy     (in_busy),
    .strip       (strip)
  );

  scff_cluster u_cluster (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .strip (strip),
    .push  (push)
  );

  scff_res_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .head     (head),
    .count    (count)
  );

  // Output packing
  assign m_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, head.cluster_count,
                    head.total_charge, head.strip_count, head.first_strip};
  assign m_tuser = head.kind;
  assign m_tlast = head.last_result;

endmodule

// ----- design/scff_checker.sv -----
module scff_checker
  import scff_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   m_tlast
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
      $stable(m_tlast))
    else $error("stalled result changed");

  // A result transferred without tlast is followed at once by a valid summary
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == KIND_SUMMARY))
    else $error("record not followed by summary");

  // A summary always closes the results of its event
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_SUMMARY) |-> m_tlast)
    else $error("summary without tlast");

  // Reset empties the result queue
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind strip_cluster_finder_filter_top scff_checker u_checker (.*);
